// ===== hdl/variable_partition_allocator_defines.svh =====
// Assertion macros for the variable partition allocator.
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define VPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VPA_ASSERT(label, clk, rst_n, prop, msg)
`define VPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/vpa_pkg.sv =====
package vpa_pkg;
  localparam int MAX_SEGS = 32;
  localparam int ADDR_BITS = 16;
  localparam int IDX_BITS = $clog2(MAX_SEGS);
  localparam int CNT_BITS = $clog2(MAX_SEGS + 1);
  localparam int ENT_BITS = 2 * ADDR_BITS + 17;
  localparam logic [15:0] RESET_MEMORY_SIZE = 16'd640;

  localparam logic [1:0] ACT_FIRST = 2'd0;
  localparam logic [1:0] ACT_BEST = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_BAD = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic busy;
    logic [15:0] owner;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SHUP_RD, S_SHUP_WR, S_ALLOC_WR,
    S_REL_RDN, S_REL_RDP, S_REL_MERGE, S_SHDN_RD, S_SHDN_WR, S_DONE
  } state_t;
endpackage

// ===== hdl/variable_partition_allocator.sv =====
// Variable partition allocator.
// Host writes cfg_memory_size through cfg_we/cfg_wdata while idle; each write,
// and reset, reinitialize the table to one free segment from address 0.
// A request word (in_action, in_job_id, in_request_size) is taken when start
// is high and busy is low. One result word (out_status, out_address) appears
// for a single cycle with out_valid; the receiver cannot stall it.
// The table lives in one single-port-write RAM with a registered read. Each
// request scans the used entries with a wait state after each read, then
// shifts entries up by one to split a segment, or down by one or two to merge
// on release, with a read state and a write state per moved entry. Bad
// requests skip the scan and go straight to S_DONE to show their result.
// Entry 0 is held in RAM and rewritten in the cycle after reset or a size
// write; only entries below the segment count are ever used.
// busy stays high from acceptance until the cycle the result is shown.
module variable_partition_allocator (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_action,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_request_size,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic [15:0] out_address
);
`include "variable_partition_allocator_defines.svh"
  localparam int IB = vpa_pkg::IDX_BITS;
  localparam int CB = vpa_pkg::CNT_BITS;
  localparam int AB = vpa_pkg::ADDR_BITS;

  vpa_pkg::state_t state_r, state_nxt;
  logic [15:0] msize_r, msize_nxt;
  logic init_r, init_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] i_r, i_nxt;
  logic [IB-1:0] pick_r, pick_nxt;
  logic found_r, found_nxt;
  logic [AB-1:0] slack_r, slack_nxt;
  logic [1:0] act_r, act_nxt;
  logic [15:0] id_r, id_nxt;
  logic [AB-1:0] req_r, req_nxt;
  logic [2:0] st_r, st_nxt;
  logic [15:0] addr_r, addr_nxt;
  vpa_pkg::seg_t cur_r, cur_nxt, nb_r, nb_nxt;
  logic [1:0] rm_r, rm_nxt;
  logic vld_r, vld_nxt;

  logic we;
  logic [IB-1:0] waddr, raddr;
  vpa_pkg::seg_t wdata, rdata;

  vpa_ram #(.WIDTH(vpa_pkg::ENT_BITS), .DEPTH(vpa_pkg::MAX_SEGS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic fit;
  logic [AB-1:0] sl;
  assign sl = rdata.size - req_r;
  assign fit = !rdata.busy && (rdata.size >= req_r);

  always_comb begin
    state_nxt = state_r;
    msize_nxt = msize_r;
    init_nxt = 1'b0;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    pick_nxt = pick_r;
    found_nxt = found_r;
    slack_nxt = slack_r;
    act_nxt = act_r;
    id_nxt = id_r;
    req_nxt = req_r;
    st_nxt = st_r;
    addr_nxt = addr_r;
    cur_nxt = cur_r;
    nb_nxt = nb_r;
    rm_nxt = rm_r;
    case (state_r)
      vpa_pkg::S_IDLE: begin
        if (cfg_we) begin
          msize_nxt = cfg_wdata;
          init_nxt = 1'b1;
          cnt_nxt = CB'(1);
        end else if (start && !init_r) begin
          act_nxt = in_action;
          id_nxt = in_job_id;
          req_nxt = AB'(in_request_size);
          i_nxt = '0;
          found_nxt = 1'b0;
          slack_nxt = '0;
          addr_nxt = '0;
          if (in_job_id == 16'd0 || in_action == 2'd3 ||
              (in_action != vpa_pkg::ACT_RELEASE && in_request_size == 16'd0)) begin
            st_nxt = vpa_pkg::ST_BAD;
            state_nxt = vpa_pkg::S_DONE;
          end else begin
            state_nxt = vpa_pkg::S_SCAN;
          end
        end
      end
      vpa_pkg::S_SCAN: begin
        if (i_r >= cnt_r) begin
          state_nxt = vpa_pkg::S_DECIDE;
        end else begin
          state_nxt = vpa_pkg::S_SCAN_WAIT;
        end
      end
      vpa_pkg::S_SCAN_WAIT: begin
        state_nxt = vpa_pkg::S_SCAN;
        i_nxt = i_r + CB'(1);
        if (act_r == vpa_pkg::ACT_RELEASE) begin
          if (rdata.busy && rdata.owner == id_r) begin
            found_nxt = 1'b1;
            pick_nxt = i_r[IB-1:0];
            cur_nxt = rdata;
            state_nxt = vpa_pkg::S_DECIDE;
          end
        end else if (fit && (!found_r || (act_r == vpa_pkg::ACT_BEST && sl < slack_r))) begin
          found_nxt = 1'b1;
          pick_nxt = i_r[IB-1:0];
          slack_nxt = sl;
          cur_nxt = rdata;
          if (act_r == vpa_pkg::ACT_FIRST || sl == '0) begin
            state_nxt = vpa_pkg::S_DECIDE;
          end
        end
      end
      vpa_pkg::S_DECIDE: begin
        if (!found_r) begin
          st_nxt = (act_r == vpa_pkg::ACT_RELEASE) ? vpa_pkg::ST_NOTFOUND
                                                   : vpa_pkg::ST_NOFIT;
          state_nxt = vpa_pkg::S_DONE;
        end else if (act_r == vpa_pkg::ACT_RELEASE) begin
          st_nxt = vpa_pkg::ST_OK;
          addr_nxt = 16'(cur_r.start);
          cur_nxt.busy = 1'b0;
          cur_nxt.owner = '0;
          rm_nxt = 2'd0;
          state_nxt = vpa_pkg::S_REL_RDN;
        end else if (slack_r == '0) begin
          st_nxt = vpa_pkg::ST_OK;
          addr_nxt = 16'(cur_r.start);
          state_nxt = vpa_pkg::S_ALLOC_WR;
        end else if (cnt_r >= CB'(vpa_pkg::MAX_SEGS)) begin
          st_nxt = vpa_pkg::ST_FULL;
          state_nxt = vpa_pkg::S_DONE;
        end else begin
          st_nxt = vpa_pkg::ST_OK;
          addr_nxt = 16'(cur_r.start);
          i_nxt = cnt_r;
          state_nxt = vpa_pkg::S_SHUP_RD;
        end
      end
      vpa_pkg::S_SHUP_RD: begin
        if (i_r <= CB'(pick_r) + CB'(1)) begin
          state_nxt = vpa_pkg::S_ALLOC_WR;
        end else begin
          state_nxt = vpa_pkg::S_SHUP_WR;
        end
      end
      vpa_pkg::S_SHUP_WR: begin
        i_nxt = i_r - CB'(1);
        state_nxt = vpa_pkg::S_SHUP_RD;
      end
      vpa_pkg::S_ALLOC_WR: begin
        if (slack_r != '0 && i_r != '0) begin
          i_nxt = '0;
          cnt_nxt = cnt_r + CB'(1);
        end else begin
          state_nxt = vpa_pkg::S_DONE;
        end
      end
      vpa_pkg::S_REL_RDN: begin
        state_nxt = vpa_pkg::S_REL_RDP;
      end
      vpa_pkg::S_REL_RDP: begin
        if (CB'(pick_r) + CB'(1) < cnt_r && !rdata.busy) begin
          cur_nxt.size = cur_r.size + rdata.size;
          rm_nxt = 2'd1;
        end
        state_nxt = vpa_pkg::S_REL_MERGE;
      end
      vpa_pkg::S_REL_MERGE: begin
        if (pick_r != '0 && !rdata.busy) begin
          nb_nxt = rdata;
          nb_nxt.size = rdata.size + cur_r.size;
          rm_nxt = rm_r + 2'd1;
        end else begin
          nb_nxt = cur_r;
        end
        i_nxt = CB'(pick_r) + CB'(1) + CB'(rm_r);
        state_nxt = vpa_pkg::S_SHDN_RD;
      end
      vpa_pkg::S_SHDN_RD: begin
        if (i_r >= cnt_r || rm_r == 2'd0) begin
          cnt_nxt = cnt_r - CB'(rm_r);
          state_nxt = vpa_pkg::S_DONE;
        end else begin
          state_nxt = vpa_pkg::S_SHDN_WR;
        end
      end
      vpa_pkg::S_SHDN_WR: begin
        i_nxt = i_r + CB'(1);
        state_nxt = vpa_pkg::S_SHDN_RD;
      end
      vpa_pkg::S_DONE: begin
        state_nxt = vpa_pkg::S_IDLE;
      end
      default: state_nxt = vpa_pkg::S_IDLE;
    endcase
  end

  // Release merge mapping: after S_REL_MERGE, nb_r holds the entry that lands at
  // the lowest touched index, written in S_REL_MERGE; later entries move down by rm_r.
  logic [IB-1:0] rel_base;
  assign rel_base = (pick_r != '0 && !rdata.busy) ? pick_r - IB'(1) : pick_r;

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = cur_r;
    raddr = i_r[IB-1:0];
    case (state_r)
      vpa_pkg::S_IDLE: begin
        if (init_r) begin
          we = 1'b1;
          waddr = '0;
          wdata.start = '0;
          wdata.size = AB'(msize_r);
          wdata.busy = 1'b0;
          wdata.owner = '0;
        end
      end
      vpa_pkg::S_SHUP_RD: raddr = IB'(i_r - CB'(1));
      vpa_pkg::S_SHUP_WR: begin
        we = 1'b1;
        waddr = i_r[IB-1:0];
        wdata = rdata;
      end
      vpa_pkg::S_ALLOC_WR: begin
        we = 1'b1;
        if (slack_r != '0 && i_r != '0) begin
          waddr = pick_r + IB'(1);
          wdata.start = cur_r.start + req_r;
          wdata.size = slack_r;
          wdata.busy = 1'b0;
          wdata.owner = '0;
        end else begin
          waddr = pick_r;
          wdata.start = cur_r.start;
          wdata.size = (slack_r != '0) ? req_r : cur_r.size;
          wdata.busy = 1'b1;
          wdata.owner = id_r;
        end
      end
      vpa_pkg::S_REL_RDN: raddr = pick_r + IB'(1);
      vpa_pkg::S_REL_RDP: raddr = pick_r - IB'(1);
      vpa_pkg::S_REL_MERGE: begin
        we = 1'b1;
        waddr = rel_base;
        wdata = (pick_r != '0 && !rdata.busy) ? nb_nxt : cur_r;
      end
      vpa_pkg::S_SHDN_RD: raddr = i_r[IB-1:0];
      vpa_pkg::S_SHDN_WR: begin
        we = 1'b1;
        waddr = IB'(i_r - CB'(rm_r));
        wdata = rdata;
      end
      default: ;
    endcase
  end

  assign vld_nxt = (state_r == vpa_pkg::S_DONE);
  assign busy = (state_r != vpa_pkg::S_IDLE) || init_r;
  assign out_valid = vld_r;
  assign out_status = st_r;
  assign out_address = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpa_pkg::S_IDLE;
      msize_r <= vpa_pkg::RESET_MEMORY_SIZE;
      init_r <= 1'b1;
      cnt_r <= CB'(1);
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      msize_r <= msize_nxt;
      init_r <= init_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
    i_r <= i_nxt;
    pick_r <= pick_nxt;
    found_r <= found_nxt;
    slack_r <= slack_nxt;
    act_r <= act_nxt;
    id_r <= id_nxt;
    req_r <= req_nxt;
    st_r <= st_nxt;
    addr_r <= addr_nxt;
    cur_r <= cur_nxt;
    nb_r <= nb_nxt;
    rm_r <= rm_nxt;
  end

  `VPA_ASSERT(a_cnt_range, clk, rst_n, (cnt_r >= CB'(1) && cnt_r <= CB'(vpa_pkg::MAX_SEGS)), "segment count out of range")
  `VPA_ASSERT(a_err_addr, clk, rst_n, (out_valid && out_status != vpa_pkg::ST_OK) |-> (out_address == 16'd0), "error result with nonzero address")
  `VPA_ASSERT(a_done_valid, clk, rst_n, (state_r == vpa_pkg::S_DONE) |=> out_valid, "result not shown after done")
  `VPA_ASSERT(a_valid_pulse, clk, rst_n, out_valid |=> !out_valid, "result shown for more than one cycle")
endmodule

// ===== hdl/vpa_ram.sv =====
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
